/* hw/rtl/tick_time_format_converter_unit_defines.svh */
// Assertion macros for the tick and time format converter RTL.
`ifndef TICK_TIME_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define TICK_TIME_FORMAT_CONVERTER_UNIT_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define TTFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TTFC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/ttfc_pkg.sv */
// Types, constants and arithmetic helpers of the tick and time format converter.
`default_nettype none
package ttfc_pkg;

   localparam int NANO_DIGITS  = 9;
   localparam int MICRO_DIGITS = 6;

   localparam logic KIND_TO_TIME  = 1'b0;
   localparam logic KIND_TO_TICKS = 1'b1;

   localparam logic [31:0] RATE_RESET = 32'd10000000;

   function automatic logic [31:0] pow10(input int n);
      logic [31:0] p;
      p = 32'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 32'd10;
      end
      return p;
   endfunction

   localparam logic [31:0] NANO_SCALE  = pow10(NANO_DIGITS);
   localparam logic [31:0] MICRO_SCALE = pow10(MICRO_DIGITS);

   typedef struct packed {
      logic        kind;
      logic        micro_precision;
      logic [63:0] tick_count;
      logic [63:0] whole_seconds;
      logic [29:0] fraction_in;
   } ttfc_req_type;

   typedef struct packed {
      logic [63:0] tick_result;
      logic [63:0] seconds_result;
      logic [29:0] fraction_result;
   } ttfc_rsp_type;

   typedef struct packed {
      logic        kind;
      logic        micro;
      logic [63:0] num;
      logic [63:0] secs;
   } ttfc_work_type;

   // Divisor of the first division and of the second one: the tick rate for ticks to time,
   // the decimal scale for time to ticks.
   function automatic logic [31:0] divisor_of(input logic kind, input logic micro,
                                              input logic [31:0] rate);
      logic [31:0] scale;
      scale = micro ? MICRO_SCALE : NANO_SCALE;
      return (kind == KIND_TO_TICKS) ? scale : rate;
   endfunction

   // One restoring division step: returns the quotient bit over the new remainder.
   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic bit_in,
                                            input logic [31:0] d);
      logic [32:0] trial;
      logic [32:0] diff;
      logic        ge;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, d};
      ge    = trial >= {1'b0, d};
      return {ge, ge ? diff[31:0] : trial[31:0]};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/tick_time_format_converter_unit.sv */
// Top level of the tick and time format converter.
//
// Requests enter through a queue interface: a transfer happens when req_push is high and
// req_full is low. Kind 0 turns req_data.tick_count into whole seconds and a nanosecond or
// microsecond fraction; kind 1 turns whole seconds and a fraction back into ticks.
// Results leave through a second queue: rsp_data holds the oldest result while rsp_empty is
// low, and a transfer happens when rsp_pop is high and rsp_empty is low.
// The tick rate is to be written through csr_we and csr_wdata only while no request is in
// flight; the block itself does not enforce this. A request passes through the input queue,
// the 64 restoring division stages, one product stage, 32 division stages and the result
// queue. One request is taken every cycle unless a full result queue holds the pipeline.
// Reset empties both queues and the pipeline and sets the tick rate to ten million.
// When the receiver stops popping, the result queue fills, the pipeline holds, the input
// queue fills and req_full rises; no result is lost.
`default_nettype none
module tick_time_format_converter_unit import ttfc_pkg::*; #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output      logic         req_full,
   input  wire ttfc_req_type req_data,
   output      logic         rsp_empty,
   input  wire logic         rsp_pop,
   output      ttfc_rsp_type rsp_data,
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata
);
   logic [31:0]   rate_ff, rate_in;
   ttfc_work_type front_work;
   ttfc_work_type mid_work;
   logic          mid_empty;
   logic          mid_pop;
   logic          out_full;
   logic          out_push;
   ttfc_rsp_type  out_data;

   assign rate_in = csr_we ? csr_wdata : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   ttfc_front u_front (
      .req  (req_data),
      .work (front_work)
   );

   ttfc_fifo #(
      .WIDTH ($bits(ttfc_work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_work),
      .full  (req_full),
      .pop   (mid_pop),
      .rdata (mid_work),
      .empty (mid_empty)
   );

   ttfc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rate     (rate_ff),
      .in_valid (!mid_empty),
      .in_work  (mid_work),
      .in_pop   (mid_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   ttfc_fifo #(
      .WIDTH ($bits(ttfc_rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );
endmodule
`default_nettype wire

/* hw/rtl/ttfc_fifo.sv */
// Small first-in first-out queue built from registers.
`default_nettype none
module ttfc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rdata,
   output      logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/ttfc_front.sv */
// Front end: sorts an accepted request into the dividend and operands of the work item.
`default_nettype none
module ttfc_front import ttfc_pkg::*; (
   input  wire ttfc_req_type  req,
   output      ttfc_work_type work
);
   always_comb begin
      work.kind  = req.kind;
      work.micro = req.micro_precision;
      work.secs  = req.whole_seconds;
      if (req.kind == KIND_TO_TICKS) begin
         work.num = {34'd0, req.fraction_in};
      end else begin
         work.num = req.tick_count;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/ttfc_back.sv */
// Back end: pipelined divisions and products that produce one result per cycle while out_full does not stall them.
`default_nettype none
`include "tick_time_format_converter_unit_defines.svh"
module ttfc_back import ttfc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [31:0]   rate,
   input  wire logic          in_valid,
   input  wire ttfc_work_type in_work,
   output      logic          in_pop,
   input  wire logic          out_full,
   output      logic          out_push,
   output      ttfc_rsp_type  out_data
);
   localparam int A_STEPS = 64;
   localparam int B_STEPS = 32;

   typedef struct packed {
      logic        kind;
      logic        micro;
      logic [63:0] num;
      logic [31:0] rem;
      logic [63:0] secs;
   } stage_a_type;

   typedef struct packed {
      logic        kind;
      logic        micro;
      logic [63:0] quot;
      logic [63:0] prod;
      logic [63:0] plo;
      logic [31:0] phi;
   } stage_m_type;

   typedef struct packed {
      logic        kind;
      logic        micro;
      logic [63:0] quot;
      logic [31:0] num;
      logic [31:0] rem;
      logic [63:0] sprod;
   } stage_b_type;

   stage_a_type        a_ff [A_STEPS];
   stage_a_type        a_in [A_STEPS];
   stage_a_type        a_src [A_STEPS];
   logic [A_STEPS-1:0] a_vld_ff;
   stage_m_type        m_ff, m_in;
   logic               m_vld_ff;
   stage_b_type        b_ff [B_STEPS];
   stage_b_type        b_in [B_STEPS];
   stage_b_type        b_src [B_STEPS];
   logic [B_STEPS-1:0] b_vld_ff;
   logic               last_valid;
   logic               adv;
   logic [31:0]        mul_b;

   assign last_valid = b_vld_ff[B_STEPS-1];
   assign adv        = !(last_valid && out_full);
   assign in_pop     = adv && in_valid;
   assign out_push   = last_valid && !out_full;

   for (genvar i = 0; i < A_STEPS; i++) begin : g_a
      logic [32:0] st;
      if (i == 0) begin : g_first
         assign a_src[i] = '{kind: in_work.kind, micro: in_work.micro, num: in_work.num,
                             rem: 32'd0, secs: in_work.secs};
      end else begin : g_next
         assign a_src[i] = a_ff[i-1];
      end
      assign st = div_step(a_src[i].rem, a_src[i].num[63],
                           divisor_of(a_src[i].kind, a_src[i].micro, rate));
      assign a_in[i] = '{kind: a_src[i].kind, micro: a_src[i].micro,
                         num: {a_src[i].num[62:0], st[32]}, rem: st[31:0],
                         secs: a_src[i].secs};
   end

   always_comb begin
      mul_b      = (a_ff[A_STEPS-1].kind == KIND_TO_TICKS) ? rate :
                   (a_ff[A_STEPS-1].micro ? MICRO_SCALE : NANO_SCALE);
      m_in.kind  = a_ff[A_STEPS-1].kind;
      m_in.micro = a_ff[A_STEPS-1].micro;
      m_in.quot  = a_ff[A_STEPS-1].num;
      m_in.prod  = a_ff[A_STEPS-1].rem * mul_b;
      m_in.plo   = a_ff[A_STEPS-1].secs[31:0] * rate;
      m_in.phi   = a_ff[A_STEPS-1].secs[63:32] * rate;
   end

   for (genvar j = 0; j < B_STEPS; j++) begin : g_b
      logic [32:0] st;
      if (j == 0) begin : g_first
         assign b_src[j] = '{kind: m_ff.kind, micro: m_ff.micro, quot: m_ff.quot,
                             num: m_ff.prod[31:0], rem: m_ff.prod[63:32],
                             sprod: m_ff.plo + {m_ff.phi, 32'd0}};
      end else begin : g_next
         assign b_src[j] = b_ff[j-1];
      end
      assign st = div_step(b_src[j].rem, b_src[j].num[31],
                           divisor_of(b_src[j].kind, b_src[j].micro, rate));
      assign b_in[j] = '{kind: b_src[j].kind, micro: b_src[j].micro, quot: b_src[j].quot,
                         num: {b_src[j].num[30:0], st[32]}, rem: st[31:0],
                         sprod: b_src[j].sprod};
   end

   always_comb begin
      out_data = '0;
      if (b_ff[B_STEPS-1].kind == KIND_TO_TICKS) begin
         out_data.tick_result = {32'd0, b_ff[B_STEPS-1].num} + b_ff[B_STEPS-1].sprod;
      end else begin
         out_data.seconds_result  = b_ff[B_STEPS-1].quot;
         out_data.fraction_result = (rate == 32'd0) ? 30'd0 : b_ff[B_STEPS-1].num[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         m_vld_ff <= 1'b0;
         b_vld_ff <= '0;
      end else if (adv) begin
         a_vld_ff <= {a_vld_ff[A_STEPS-2:0], in_valid};
         m_vld_ff <= a_vld_ff[A_STEPS-1];
         b_vld_ff <= {b_vld_ff[B_STEPS-2:0], m_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         m_ff <= m_in;
         b_ff <= b_in;
      end
   end

   `TTFC_ASSERT(back_hold_on_stall, (last_valid && out_full) |=> (last_valid && $stable(b_ff[B_STEPS-1])), "Result stage changed during a stall.")
   `TTFC_ASSERT(back_product_moves_on, (m_vld_ff && adv) |=> b_vld_ff[0], "Product stage item was lost.")
   `TTFC_ASSERT_ALWAYS(back_reset_clears, reset |=> (!last_valid && !m_vld_ff), "Pipeline not cleared by reset.")
endmodule
`default_nettype wire
